FILE: hdl/mcke_pkg.sv
// Types and constants shared by the Morse keyer encoder sequencer and top level.
// Holds the symbol table, the microcode word layout and the program entry points.
package mcke_pkg;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_DOT  = 2'd0,
		REG_DASH = 2'd1,
		REG_GAP  = 2'd2,
		REG_WORD = 2'd3
	} reg_idx_t;

	// microprogram counter and entry points
	typedef logic [1:0] pc_t;
	localparam pc_t S_MARK  = 2'd0;
	localparam pc_t S_GAP   = 2'd1;
	localparam pc_t S_SPACE = 2'd2;
	localparam pc_t S_EOW   = 2'd3;

	typedef enum logic [1:0] {
		U_DOT  = 2'd0,
		U_DASH = 2'd1,
		U_GAP  = 2'd2,
		U_WORD = 2'd3
	} units_sel_t;

	typedef enum logic [1:0] {
		C_ALWAYS = 2'd0,
		C_MORE   = 2'd1,
		C_EOW    = 2'd2,
		C_END    = 2'd3
	} cond_t;

	typedef struct packed {
		logic       key_on;
		units_sel_t sel;
		logic       shift;
		cond_t      cond;
		pc_t        target;
	} ucode_t;

	// one segment handed from the sequencer to the output stage
	typedef struct packed {
		logic       key_on;
		units_sel_t sel;
		logic       last;
	} seg_t;

	localparam int SYM_W = 5;
	localparam int LEN_W = 3;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [SYM_W-1:0] bits;
	} sym_t;

	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_Z_UP  = 8'h5a;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_Z_LO  = 8'h7a;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CASE_OFS = 8'h20;
	localparam logic [7:0] DIGIT_BASE = 8'd26;

	// first symbol in bits[4], 1 = dash; index 0..25 letters, 26..35 digits
	function automatic sym_t sym_lookup(input logic [5:0] idx);
		sym_t s;
		unique case (idx)
			6'd0:  s = '{3'd2, 5'b01000};
			6'd1:  s = '{3'd4, 5'b10000};
			6'd2:  s = '{3'd4, 5'b10100};
			6'd3:  s = '{3'd3, 5'b10000};
			6'd4:  s = '{3'd1, 5'b00000};
			6'd5:  s = '{3'd4, 5'b00100};
			6'd6:  s = '{3'd3, 5'b11000};
			6'd7:  s = '{3'd4, 5'b00000};
			6'd8:  s = '{3'd2, 5'b00000};
			6'd9:  s = '{3'd4, 5'b01110};
			6'd10: s = '{3'd3, 5'b10100};
			6'd11: s = '{3'd4, 5'b01000};
			6'd12: s = '{3'd2, 5'b11000};
			6'd13: s = '{3'd2, 5'b10000};
			6'd14: s = '{3'd3, 5'b11100};
			6'd15: s = '{3'd4, 5'b01100};
			6'd16: s = '{3'd4, 5'b11010};
			6'd17: s = '{3'd3, 5'b01000};
			6'd18: s = '{3'd3, 5'b00000};
			6'd19: s = '{3'd1, 5'b10000};
			6'd20: s = '{3'd3, 5'b00100};
			6'd21: s = '{3'd4, 5'b00010};
			6'd22: s = '{3'd3, 5'b01100};
			6'd23: s = '{3'd4, 5'b10010};
			6'd24: s = '{3'd4, 5'b10110};
			6'd25: s = '{3'd4, 5'b11000};
			6'd26: s = '{3'd5, 5'b11111};
			6'd27: s = '{3'd5, 5'b01111};
			6'd28: s = '{3'd5, 5'b00111};
			6'd29: s = '{3'd5, 5'b00011};
			6'd30: s = '{3'd5, 5'b00001};
			6'd31: s = '{3'd5, 5'b00000};
			6'd32: s = '{3'd5, 5'b10000};
			6'd33: s = '{3'd5, 5'b11000};
			6'd34: s = '{3'd5, 5'b11100};
			6'd35: s = '{3'd5, 5'b11110};
			default: s = '{3'd0, 5'b00000};
		endcase
		return s;
	endfunction

endpackage

FILE: hdl/mcke_seq.sv
// Microcoded sequencer for the Morse keyer encoder: program rom, step counter,
// symbol shifter and branch logic. Depends on mcke_pkg.
module mcke_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  mcke_pkg::pc_t               entry,
	input  mcke_pkg::sym_t              sym,
	input  logic                        eow,
	input  logic                        advance,
	output logic                        busy,
	output logic                        step,
	output mcke_pkg::seg_t              seg
);
	import mcke_pkg::*;

	// mark, gap (loops back while symbols remain), space, word gap
	localparam ucode_t ROM [4] = '{
		'{1'b1, U_DOT,  1'b0, C_ALWAYS, S_GAP},
		'{1'b0, U_GAP,  1'b1, C_MORE,   S_MARK},
		'{1'b0, U_WORD, 1'b0, C_EOW,    S_EOW},
		'{1'b0, U_WORD, 1'b0, C_END,    S_EOW}
	};

	pc_t              pc_q;
	logic             busy_q;
	logic             eow_q;
	logic [LEN_W-1:0] cnt_q;
	logic [SYM_W-1:0] bits_q;
	ucode_t           w;
	pc_t              pc_nxt;
	logic             done;
	logic             more;

	assign w    = ROM[pc_q];
	assign more = cnt_q > LEN_W'(1);
	assign busy = busy_q;
	assign step = busy_q && advance;

	always_comb begin
		pc_nxt = w.target;
		done   = 1'b0;
		case (w.cond)
			C_ALWAYS: begin
				done = 1'b0;
			end
			C_MORE: begin
				if (!more) begin
					pc_nxt = S_EOW;
					done   = !eow_q;
				end
			end
			C_EOW: begin
				pc_nxt = S_EOW;
				done   = !eow_q;
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	always_comb begin
		seg.key_on = w.key_on;
		seg.last   = done;
		// a mark step takes dot or dash length from the current symbol
		seg.sel    = (w.sel == U_DOT && bits_q[SYM_W-1]) ? U_DASH : w.sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= S_MARK;
		end else if (start) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
		end else if (step) begin
			busy_q <= !done;
			pc_q   <= pc_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			eow_q  <= eow;
			cnt_q  <= sym.len;
			bits_q <= sym.bits;
		end else if (step && w.shift) begin
			cnt_q  <= cnt_q - LEN_W'(1);
			bits_q <= {bits_q[SYM_W-2:0], 1'b0};
		end
	end

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("start while sequencer busy");
	a_mark_has_sym: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && pc_q == S_MARK) |-> cnt_q != '0) else $error("mark with no symbol left");
	a_eow_step: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && pc_q == S_EOW) |-> eow_q) else $error("word gap without end of word");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && seg.last) |=> !busy_q) else $error("still busy after last segment");
`endif

endmodule

FILE: hdl/morse_char_keyer_encoder.sv
// Top level of the Morse keyer encoder: configuration registers, character
// decode, sequencer and output register. Depends on mcke_pkg and mcke_seq.
//
//   channel  | direction | payload
//   s_*      | in        | tdata = char_code[7:0], tlast = end_of_word
//   m_*      | out       | tdata = units[7:0], tuser = key_on, tlast = last
//   cfg_*    | in        | cfg_addr selects dot, dash, gap, word units
//
// a character issues two segments per symbol, one for a space and one for end of
// word (at most 11), one per cycle while the output is not stalled
// input is ready again the cycle after the last segment is issued; a character
// with no segments is taken without the sequencer going busy
// reset loads 5/10/5/10 units and leaves the sequencer idle
// a stalled output holds the sequencer on its current microcode step
module morse_char_keyer_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // char_code[7:0]
	input  logic        s_tlast,   // end_of_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // units[7:0]
	output logic        m_tuser,   // key_on
	output logic        m_tlast,   // last
	input  logic        cfg_we,
	input  mcke_pkg::reg_idx_t cfg_addr,
	input  logic [7:0]  cfg_wdata
);
	import mcke_pkg::*;

	logic [7:0] dot_q, dash_q, gap_q, word_q;
	logic [7:0] ch_up;
	logic [7:0] idx8;
	logic       is_letter, is_digit, is_space;
	logic       has_seg, start, busy, step, advance;
	pc_t        entry;
	sym_t       sym;
	seg_t       seg;
	logic       m_tvalid_q, m_tuser_q, m_tlast_q;
	logic [7:0] m_tdata_q;
	logic [7:0] units;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q  <= 8'd5;
			dash_q <= 8'd10;
			gap_q  <= 8'd5;
			word_q <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DOT:  dot_q  <= cfg_wdata;
				REG_DASH: dash_q <= cfg_wdata;
				REG_GAP:  gap_q  <= cfg_wdata;
				REG_WORD: word_q <= cfg_wdata;
				default:  ;
			endcase
		end
	end

	always_comb begin
		ch_up = (s_tdata >= CH_A_LO && s_tdata <= CH_Z_LO) ? s_tdata - CASE_OFS : s_tdata;
		is_letter = ch_up >= CH_A_UP && ch_up <= CH_Z_UP;
		is_digit  = s_tdata >= CH_0 && s_tdata <= CH_9;
		is_space  = s_tdata == CH_SPACE;
		idx8      = is_letter ? ch_up - CH_A_UP : s_tdata - CH_0 + DIGIT_BASE;
		sym       = (is_letter || is_digit) ? sym_lookup(idx8[5:0]) : '0;
		has_seg   = is_letter || is_digit || is_space || s_tlast;
		if (is_letter || is_digit)
			entry = S_MARK;
		else if (is_space)
			entry = S_SPACE;
		else
			entry = S_EOW;
	end

	assign s_tready = !busy;
	assign start    = s_tvalid && s_tready && has_seg;
	assign advance  = !m_tvalid_q || m_tready;

	mcke_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.entry   (entry),
		.sym     (sym),
		.eow     (s_tlast),
		.advance (advance),
		.busy    (busy),
		.step    (step),
		.seg     (seg)
	);

	always_comb begin
		unique case (seg.sel)
			U_DOT:   units = dot_q;
			U_DASH:  units = dash_q;
			U_GAP:   units = gap_q;
			default: units = word_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata_q <= units;
			m_tuser_q <= seg.key_on;
			m_tlast_q <= seg.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

FILE: bench/morse_char_keyer_encoder_test.sv
// Self-checking bench for morse_char_keyer_encoder: streams characters in, checks every
// key segment against an in-bench Morse encoder. Depends on mcke_pkg and the RTL only.
module morse_char_keyer_encoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import mcke_pkg::*;

	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 400;
	localparam int LIMIT_NS      = 5_000_000;

	typedef struct {
		logic [7:0] code;
		logic       eow;
	} char_beat_t;

	typedef struct {
		logic       key_on;
		logic [7:0] units;
		logic       last;
	} segment_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [7:0]         s_tdata;   // char_code[7:0]
	logic               s_tlast;   // end_of_word
	logic               m_tvalid;
	logic               m_tready;
	logic [7:0]         m_tdata;   // units[7:0]
	logic               m_tuser;   // key_on
	logic               m_tlast;   // last
	logic               cfg_we;
	reg_idx_t           cfg_addr;
	logic [7:0]         cfg_wdata;

	// timing as the block should currently hold it
	logic [7:0] dot_len, dash_len, gap_len, word_len;

	char_beat_t char_queue[$];
	segment_t   pending_segments[$];

	int send_idle_pct;
	int recv_stall_pct;
	logic hold_request;
	logic hold_on;
	int errors;
	int chars_sent;
	int segments_seen;
	int settings_used;

	string letter_pat [26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
		".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-", "..-",
		"...-", ".--", "-..-", "-.--", "--.."};
	string digit_pat [10] = '{"-----", ".----", "..---", "...--", "....-", ".....", "-....",
		"--...", "---..", "----."};

	morse_char_keyer_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// turns one character into the key segments it should produce
	function automatic void encode_char(input logic [7:0] code, input logic eow);
		string pat;
		logic [7:0] c;
		segment_t segs[$];
		segment_t seg;
		pat = "";
		c = code;
		if (c >= "a" && c <= "z")
			c = c - 8'h20;
		if (c >= "A" && c <= "Z") begin
			pat = letter_pat[c - "A"];
		end else if (c >= "0" && c <= "9") begin
			pat = digit_pat[c - "0"];
		end else if (c == " ") begin
			segs.push_back('{1'b0, word_len, 1'b0});
		end
		for (int k = 0; k < pat.len(); k++) begin
			segs.push_back('{1'b1, (pat[k] == ".") ? dot_len : dash_len, 1'b0});
			segs.push_back('{1'b0, gap_len, 1'b0});
		end
		if (eow)
			segs.push_back('{1'b0, word_len, 1'b0});
		foreach (segs[i]) begin
			seg = segs[i];
			seg.last = (i == segs.size() - 1);
			pending_segments.push_back(seg);
		end
	endfunction

	// mostly text, the rest arbitrary bytes
	function automatic char_beat_t random_char();
		char_beat_t b;
		int pick;
		pick = $urandom_range(99);
		if (pick < 45) begin
			b.code = 8'("A" + $urandom_range(25));
			if ($urandom_range(1))
				b.code = b.code + 8'h20;
		end else if (pick < 60) begin
			b.code = 8'("0" + $urandom_range(9));
		end else if (pick < 75) begin
			b.code = " ";
		end else begin
			b.code = 8'($urandom_range(255));
		end
		b.eow = ($urandom_range(3) == 0);
		return b;
	endfunction

	function automatic void queue_char(input logic [7:0] code, input logic eow);
		char_queue.push_back('{code, eow});
	endfunction

	task automatic load_timing(input logic [7:0] dot, input logic [7:0] dash,
			input logic [7:0] gap, input logic [7:0] word);
		reg_idx_t idx [4];
		logic [7:0] vals [4];
		idx = '{REG_DOT, REG_DASH, REG_GAP, REG_WORD};
		vals = '{dot, dash, gap, word};
		for (int i = 0; i < 4; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_addr <= idx[i];
			cfg_wdata <= vals[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		dot_len = dot;
		dash_len = dash;
		gap_len = gap;
		word_len = word;
		settings_used++;
	endtask

	// sender drained, every segment in, then a quiet settle period
	task automatic wait_idle();
		do
			@(posedge clk);
		while (char_queue.size() != 0 || s_tvalid || pending_segments.size() != 0 || hold_on);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int n, input int send_idle, input int recv_stall);
		@(posedge clk);
		send_idle_pct <= send_idle;
		recv_stall_pct <= recv_stall;
		for (int i = 0; i < n; i++)
			char_queue.push_back(random_char());
		wait_idle();
	endtask

	always @(posedge clk) begin : sender
		char_beat_t beat;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				encode_char(s_tdata, s_tlast);
				chars_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					beat = char_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= beat.code;
					s_tlast <= beat.eow;
				end else begin
					s_tvalid <= 1'b0;
					s_tdata <= 8'($urandom);
					s_tlast <= 1'($urandom);
				end
			end
		end
	end

	always @(posedge clk) begin : receiver
		segment_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_segments.size() == 0) begin
					$display("%0t: unexpected segment key_on=%0b units=%0d last=%0b",
						$time, m_tuser, m_tdata, m_tlast);
					errors++;
				end else begin
					want = pending_segments.pop_front();
					if (want.key_on !== m_tuser || want.units !== m_tdata ||
							want.last !== m_tlast) begin
						// fields shown as key_on/units/last
						$display("%0t: segment expected %0b/%0d/%0b got %0b/%0d/%0b",
							$time, want.key_on, want.units, want.last,
							m_tuser, m_tdata, m_tlast);
						errors++;
					end
					segments_seen++;
				end
			end
			m_tready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one long receiver stall so the block backs up into its input
	initial begin : receiver_hold_off
		hold_on = 1'b0;
		do
			@(posedge clk);
		while (!hold_request);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin : watchdog
		#(LIMIT_NS);
		$display("timeout with %0d segments still outstanding", pending_segments.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_DOT;
		cfg_wdata = 8'h00;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b0;
		errors = 0;
		chars_sent = 0;
		segments_seen = 0;
		settings_used = 1;
		dot_len = 8'd5;
		dash_len = 8'd10;
		gap_len = 8'd5;
		word_len = 8'd10;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: table ends, both cases, space, non-table codes at every boundary
		queue_char("A", 1'b0);
		queue_char("a", 1'b1);
		queue_char("Z", 1'b0);
		queue_char("z", 1'b0);
		queue_char("0", 1'b0);
		queue_char("9", 1'b1);
		queue_char("5", 1'b0);
		queue_char("E", 1'b0);
		queue_char("T", 1'b1);
		queue_char(" ", 1'b0);
		queue_char(" ", 1'b1);
		queue_char(8'h00, 1'b0);
		queue_char(8'hff, 1'b1);
		queue_char(8'h40, 1'b0);
		queue_char(8'h5b, 1'b1);
		queue_char(8'h60, 1'b0);
		queue_char(8'h7b, 1'b0);
		queue_char(8'h2f, 1'b1);
		queue_char(8'h3a, 1'b0);
		queue_char(8'h80, 1'b1);
		queue_char("Q", 1'b1);
		queue_char("m", 1'b0);
		queue_char(8'h1f, 1'b0);
		queue_char("!", 1'b1);
		wait_idle();

		load_timing(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
			8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)));
		run_random(70, 0, 0);

		load_timing(8'd1, 8'd1, 8'd1, 8'd1);
		run_random(70, 77, 0);

		load_timing(8'd255, 8'd255, 8'd255, 8'd255);
		run_random(70, 0, 77);

		// zero-length segments pass through unchanged
		load_timing(8'd0, 8'd255, 8'd0, 8'd1);
		run_random(70, 35, 35);

		load_timing(8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
			8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)));
		@(posedge clk);
		hold_request <= 1'b1;
		run_random(50, 0, 0);

		$display("covered %0d characters and %0d key segments over %0d timing settings",
			chars_sent, segments_seen, settings_used);
		$display("with zero and full-scale unit values, idle and stall mixes and a long hold-off");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
